[src/reb_pkg.sv]
// ----------------------------------------------------------------------------
// reb_pkg
// Shared types, widths and the quadrature step table for the rotary encoder
// and button input block.
// ----------------------------------------------------------------------------
package reb_pkg;

  localparam int unsigned FiltW    = 16;
  localparam int unsigned HeldW    = 24;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned EdgesPerDetent = 4;

  localparam logic [FiltW-1:0]  AbFilterRst  = FiltW'(1000);
  localparam logic [FiltW-1:0]  BtnFilterRst = FiltW'(5000);
  localparam logic [HeldW-1:0]  LongPressRst = HeldW'(700000);

  localparam logic [FiltW-1:0]  FiltCountMax = '1;
  localparam logic [HeldW-1:0]  HeldMax      = '1;
  localparam logic [CountW-1:0] CountMax     = '1;
  localparam logic signed [CountW-1:0] DeltaMax = {1'b0, {(CountW-1){1'b1}}};
  localparam logic signed [CountW-1:0] DeltaMin = {1'b1, {(CountW-1){1'b0}}};

  localparam logic signed [3:0] AccHigh = 4'(EdgesPerDetent);
  localparam logic signed [3:0] AccLow  = -4'(EdgesPerDetent);

  typedef enum logic [1:0] {
    CfgAbFilter  = 2'd0,
    CfgBtnFilter = 2'd1,
    CfgLongPress = 2'd2
  } cfg_idx_e;

  // filtered level before and after the current transaction
  typedef struct packed {
    logic level_q;
    logic level_d;
  } pin_t;

  // index is {old_ab, new_ab}, ab packed as {a, b}
  localparam logic signed [1:0] QuadSteps [16] = '{
    2'sd0,  2'sd1,  -2'sd1, 2'sd0,
    -2'sd1, 2'sd0,  2'sd0,  2'sd1,
    2'sd1,  2'sd0,  2'sd0,  -2'sd1,
    2'sd0,  -2'sd1, 2'sd1,  2'sd0
  };

  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    return QuadSteps[idx];
  endfunction

endpackage

[src/rotary_encoder_button_input.sv]
// ----------------------------------------------------------------------------
// rotary_encoder_button_input
// Quadrature encoder decoder with glitch filters and a long-press button.
// ----------------------------------------------------------------------------
// Takes one pin sample per transaction and returns one report per sample.
// A sample is held in an input register, then its filter, decode and
// counter updates run in a single pass into the result register, so one
// transaction is taken every clock unless m_axis_tready stalls the output.
// A stall on m_axis_tready holds s_axis_tready low in the same cycle once
// both registers are full. Configuration writes take effect at once and
// belong to idle periods.
module rotary_encoder_button_input (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [reb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // a_level, b_level, btn_level, pad
  input  logic                         s_axis_tuser,  // func
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // detent_delta[15:0], click_count[31:16], long_press_count[47:32],
  // button_held[48], pad
  output logic [55:0]                  m_axis_tdata
);
  import reb_pkg::*;

  // configuration
  logic [FiltW-1:0] ab_len_q, btn_len_q;
  logic [HeldW-1:0] long_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ab_len_q   <= AbFilterRst;
      btn_len_q  <= BtnFilterRst;
      long_len_q <= LongPressRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgAbFilter:  ab_len_q   <= cfg_data_i[FiltW-1:0];
        CfgBtnFilter: btn_len_q  <= cfg_data_i[FiltW-1:0];
        CfgLongPress: long_len_q <= cfg_data_i[HeldW-1:0];
        default: ;
      endcase
    end
  end

  // input register and output register handshake
  logic       in_valid_q;
  logic       func_q, a_raw_q, b_raw_q, btn_raw_q;
  logic       advance, do_step, s_accept;
  logic       out_valid_q;
  logic [55:0] out_data_q, out_data_d;

  assign advance       = !out_valid_q || m_axis_tready;
  assign do_step       = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      func_q    <= s_axis_tuser;
      a_raw_q   <= s_axis_tdata[0];
      b_raw_q   <= s_axis_tdata[1];
      btn_raw_q <= s_axis_tdata[2];
    end
  end

  // pin filters
  pin_t a_pin, b_pin, btn_pin;

  reb_filter u_filt_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (do_step),
    .raw_i  (a_raw_q),
    .len_i  (ab_len_q),
    .pin_o  (a_pin)
  );

  reb_filter u_filt_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (do_step),
    .raw_i  (b_raw_q),
    .len_i  (ab_len_q),
    .pin_o  (b_pin)
  );

  reb_filter u_filt_btn (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (do_step),
    .raw_i  (btn_raw_q),
    .len_i  (btn_len_q),
    .pin_o  (btn_pin)
  );

  // decode and counter state
  logic signed [2:0]        acc_q, acc_d;
  logic signed [CountW-1:0] delta_q, delta_d;
  logic [CountW-1:0]        click_q, click_d;
  logic [CountW-1:0]        long_q, long_d;
  logic                     pressed_q, pressed_d;
  logic                     long_sent_q, long_sent_d;
  logic [HeldW-1:0]         held_q, held_d;

  logic [1:0]        old_ab, new_ab;
  logic signed [1:0] step;
  logic signed [3:0] acc_sum;
  logic [HeldW-1:0]  threshold;

  assign old_ab    = {a_pin.level_q, b_pin.level_q};
  assign new_ab    = {a_pin.level_d, b_pin.level_d};
  assign step      = quad_step({old_ab, new_ab});
  assign acc_sum   = 4'(acc_q) + 4'(step);
  assign threshold = (long_len_q == '0) ? HeldW'(1) : long_len_q;

  always_comb begin
    acc_d       = acc_q;
    delta_d     = delta_q;
    click_d     = click_q;
    long_d      = long_q;
    pressed_d   = pressed_q;
    long_sent_d = long_sent_q;
    held_d      = held_q;

    // illegal or absent transitions decode to a zero step
    if (step != 2'sd0) begin
      if (acc_sum >= AccHigh) begin
        acc_d = '0;
        if (delta_q != DeltaMax) delta_d = delta_q + CountW'(1);
      end else if (acc_sum <= AccLow) begin
        acc_d = '0;
        if (delta_q != DeltaMin) delta_d = delta_q - CountW'(1);
      end else begin
        acc_d = acc_sum[2:0];
      end
    end

    if (btn_pin.level_q && !btn_pin.level_d) begin
      pressed_d   = 1'b1;
      held_d      = '0;
      long_sent_d = 1'b0;
    end else if (!btn_pin.level_q && btn_pin.level_d) begin
      if (pressed_q) begin
        pressed_d = 1'b0;
        if (!long_sent_q && click_q != CountMax) click_d = click_q + CountW'(1);
      end
    end else if (!btn_pin.level_d && pressed_q) begin
      held_d = (held_q != HeldMax) ? held_q + HeldW'(1) : held_q;
      if (held_d >= threshold && !long_sent_q) begin
        if (long_q != CountMax) long_d = long_q + CountW'(1);
        long_sent_d = 1'b1;
      end
    end

    out_data_d = {7'd0, !btn_pin.level_d, long_d, click_d, delta_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      delta_q     <= '0;
      click_q     <= '0;
      long_q      <= '0;
      pressed_q   <= 1'b0;
      long_sent_q <= 1'b0;
      held_q      <= '0;
    end else if (do_step) begin
      acc_q       <= acc_d;
      pressed_q   <= pressed_d;
      long_sent_q <= long_sent_d;
      held_q      <= held_d;
      // report then clear
      delta_q     <= func_q ? '0 : delta_d;
      click_q     <= func_q ? '0 : click_d;
      long_q      <= func_q ? '0 : long_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // a press in progress means the filtered button is low
  a_pressed_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pressed_q |-> !btn_pin.level_q)
    else $error("pressed flag set while filtered button released");

  // the edge sum clears before it reaches a full detent
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q != 3'sb100)
    else $error("edge accumulator reached a full detent");

  // a long press is only flagged during a held press
  a_long_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(long_sent_q) |-> pressed_q)
    else $error("long press flagged without a held press");

  // a report is produced only from a sample in the input register
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_valid_q) |=> !out_valid_q)
    else $error("report produced without a sample");

endmodule

[src/reb_filter.sv]
// ----------------------------------------------------------------------------
// reb_filter
// Glitch filter for one pin: the filtered level follows the raw level only
// after the raw level has differed from it for max(len_i, 1) consecutive samples.
// ----------------------------------------------------------------------------
module reb_filter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      raw_i,
  input  logic [reb_pkg::FiltW-1:0] len_i,
  output reb_pkg::pin_t             pin_o
);
  import reb_pkg::*;

  logic             level_q, level_d;
  logic [FiltW-1:0] count_q, count_d;
  logic [FiltW-1:0] count_inc;

  always_comb begin
    level_d   = level_q;
    count_d   = count_q;
    count_inc = (count_q != FiltCountMax) ? count_q + FiltW'(1) : count_q;
    if (raw_i == level_q) begin
      count_d = '0;
    end else if (count_inc >= len_i) begin
      count_d = '0;
      level_d = raw_i;
    end else begin
      count_d = count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b1;
      count_q <= '0;
    end else if (en_i) begin
      level_q <= level_d;
      count_q <= count_d;
    end
  end

  assign pin_o.level_q = level_q;
  assign pin_o.level_d = level_d;

endmodule

[verif/rotary_encoder_button_input_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_button_input_test
// Self-checking bench for the encoder and button input block.
// ----------------------------------------------------------------------------
// Pin samples go in over the slave stream and reports come back over the
// master stream. A behavioral copy of the filters, the quadrature decode and
// the button logic predicts reports the table leaves open. The run starts
// with a short walk through a stimulus table and continues with phases of
// random encoder and button activity under several register settings, among
// them the shortest and longest filters and a zero long-press threshold.
// ----------------------------------------------------------------------------
module rotary_encoder_button_input_test;
  import reb_pkg::*;

  localparam int unsigned StallLimit    = 1000;
  localparam int unsigned HoldoffCycles = 80;
  localparam int          Edges         = EdgesPerDetent;
  localparam int          DeltaHi       = 2 ** (CountW - 1) - 1;
  localparam int          DeltaLo       = -(2 ** (CountW - 1));
  localparam int          CountHi       = 2 ** CountW - 1;

  // position along the forward cycle 11 -> 10 -> 00 -> 01, indexed by {a, b}
  localparam int          GrayPos [4] = '{2, 3, 1, 0};
  localparam logic [1:0]  PosAb   [4] = '{2'b11, 2'b10, 2'b00, 2'b01};

  typedef struct packed {
    logic func;
    logic a;
    logic b;
    logic btn;
  } sample_t;

  typedef struct packed {
    logic signed [CountW-1:0] delta;
    logic [CountW-1:0]        clicks;
    logic [CountW-1:0]        longs;
    logic                     held;
  } report_t;

  typedef struct packed {
    bit                  is_cfg;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] val;
    logic                func;
    logic                a;
    logic                b;
    logic                btn;
    bit                  typed;
    logic [CountW-1:0]   w_delta;
    logic [CountW-1:0]   w_clicks;
    logic [CountW-1:0]   w_longs;
    logic                w_held;
  } dir_row_t;

  localparam int unsigned NumDirRows = 30;
  localparam dir_row_t DirRows [NumDirRows] = '{
    // reset settings, nothing gets through the long filters
    '{0, CfgAbFilter,  0, 0, 1, 1, 1, 1, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 1, 0, 1, 0, 1, 0, 0, 0, 0},
    '{1, CfgAbFilter,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, CfgBtnFilter, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, CfgLongPress, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // one detent forward
    '{0, CfgAbFilter,  0, 0, 1, 0, 1, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 0, 1, 1, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 1, 1, 1, 0, 0, 0, 0, 0},
    // both channels jump at once, counts nothing
    '{0, CfgAbFilter,  0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 1, 1, 1, 0, 0, 0, 0, 0},
    // one detent back
    '{0, CfgAbFilter,  0, 0, 0, 1, 1, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 1, 0, 1, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 1, 1, 1, 0, 0, 0, 0, 0},
    // long press, then a release that counts no click
    '{0, CfgAbFilter,  0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 1, 1, 1, 0, 0, 0, 0, 0},
    // short click
    '{0, CfgAbFilter,  0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 1, 1, 1, 0, 0, 0, 0, 0},
    // glitch restarts the button filter
    '{1, CfgBtnFilter, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 1, 1, 1, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
    // report and clear, then the release lands after the clear
    '{0, CfgAbFilter,  0, 1, 1, 1, 1, 0, 0, 0, 0, 0},
    '{0, CfgAbFilter,  0, 0, 1, 1, 1, 0, 0, 0, 0, 0}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  cfg_idx_e            cfg_idx_i     = CfgAbFilter;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;  // a_level, b_level, btn_level, pad
  logic                s_axis_tuser  = 1'b0;  // func
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // detent_delta[15:0], click_count[31:16], long_press_count[47:32],
  // button_held[48], pad
  logic [55:0]         m_axis_tdata;

  always #6 clk_i = ~clk_i;

  rotary_encoder_button_input dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // decoder settings and state as the block should hold them
  logic [FiltW-1:0] ab_len  = AbFilterRst;
  logic [FiltW-1:0] btn_len = BtnFilterRst;
  logic [HeldW-1:0] lp_len  = LongPressRst;

  logic [1:0]       flt_ab    = 2'b11;
  logic [FiltW-1:0] a_cnt     = '0;
  logic [FiltW-1:0] b_cnt     = '0;
  logic             flt_btn   = 1'b1;
  logic [FiltW-1:0] btn_cnt   = '0;
  int               edge_acc  = 0;
  int               detents   = 0;
  int               clicks    = 0;
  int               longs     = 0;
  bit               pressed   = 1'b0;
  bit               long_sent = 1'b0;
  logic [HeldW-1:0] held      = '0;

  report_t     owed_reports [$];
  int unsigned errors = 0;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit holdoff_pending = 1'b0;

  // intended pin levels for the random stimulus
  logic        lvl_a = 1'b1;
  logic        lvl_b = 1'b1;
  logic        lvl_btn = 1'b1;
  bit          enc_fwd = 1'b1;
  int unsigned enc_hold = 0;
  int unsigned btn_hold = 0;

  function automatic logic filter_pin(input logic raw, input logic lvl,
                                      inout logic [FiltW-1:0] cnt,
                                      input logic [FiltW-1:0] len);
    if (raw == lvl) begin
      cnt = '0;
      return lvl;
    end
    if (cnt != FiltCountMax) cnt++;
    if (cnt >= len) begin
      cnt = '0;
      return raw;
    end
    return lvl;
  endfunction

  function automatic logic [1:0] quad_neighbor(input logic [1:0] ab, input bit fwd);
    return PosAb[(GrayPos[ab] + (fwd ? 1 : 3)) % 4];
  endfunction

  function automatic report_t next_report(input sample_t s);
    report_t          r;
    logic [1:0]       ab_old;
    logic [1:0]       ab_new;
    logic             btn_old;
    logic             btn_new;
    int               move;
    logic [HeldW-1:0] thresh;
    ab_old = flt_ab;
    ab_new[1] = filter_pin(s.a, ab_old[1], a_cnt, ab_len);
    ab_new[0] = filter_pin(s.b, ab_old[0], b_cnt, ab_len);
    thresh = (lp_len == '0) ? HeldW'(1) : lp_len;
    if (ab_new != ab_old) begin
      // a jump of two positions is illegal and counts nothing
      move = (GrayPos[ab_new] - GrayPos[ab_old] + 4) % 4;
      if (move == 1) edge_acc++;
      else if (move == 3) edge_acc--;
      if (edge_acc >= Edges) begin
        if (detents < DeltaHi) detents++;
        edge_acc = 0;
      end else if (edge_acc <= -Edges) begin
        if (detents > DeltaLo) detents--;
        edge_acc = 0;
      end
    end
    flt_ab = ab_new;

    btn_old = flt_btn;
    btn_new = filter_pin(s.btn, btn_old, btn_cnt, btn_len);
    flt_btn = btn_new;
    if (btn_old && !btn_new) begin
      pressed = 1'b1;
      held = '0;
      long_sent = 1'b0;
    end else if (!btn_old && btn_new) begin
      if (pressed) begin
        pressed = 1'b0;
        if (!long_sent && clicks < CountHi) clicks++;
      end
    end else if (!btn_new && pressed) begin
      if (held != HeldMax) held++;
      if (held >= thresh && !long_sent) begin
        if (longs < CountHi) longs++;
        long_sent = 1'b1;
      end
    end

    r.delta  = CountW'(detents);
    r.clicks = CountW'(clicks);
    r.longs  = CountW'(longs);
    r.held   = !btn_new;
    if (s.func) begin
      detents = 0;
      clicks = 0;
      longs = 0;
    end
    return r;
  endfunction

  task automatic push_sample(input sample_t s, input bit typed, input report_t want);
    int unsigned gap;
    report_t     predicted;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, s.btn, s.b, s.a};
    s_axis_tuser  <= s.func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = next_report(s);
    owed_reports.push_back(typed ? want : predicted);
  endtask

  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (owed_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    drain_reports();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgAbFilter:  ab_len  = val[FiltW-1:0];
      CfgBtnFilter: btn_len = val[FiltW-1:0];
      CfgLongPress: lp_len  = val[HeldW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // encoder steps and button presses that mostly outlast the filters
  task automatic random_sample(output sample_t s);
    int unsigned roll;
    int unsigned ab_span;
    int unsigned btn_span;
    int unsigned lp_span;
    ab_span  = (ab_len > 8) ? 8 : ab_len;
    btn_span = (btn_len > 8) ? 8 : btn_len;
    lp_span  = (lp_len > 24) ? 24 : lp_len;
    if (enc_hold != 0) begin
      enc_hold--;
    end else begin
      roll = $urandom_range(0, 19);
      if (roll < 2) enc_fwd = !enc_fwd;
      if (roll == 19) {lvl_a, lvl_b} = ~{lvl_a, lvl_b};
      else if (roll != 18) {lvl_a, lvl_b} = quad_neighbor({lvl_a, lvl_b}, enc_fwd);
      enc_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(0, ab_span)
                                             : ab_span + $urandom_range(0, 3);
    end
    if (btn_hold != 0) begin
      btn_hold--;
    end else begin
      lvl_btn = !lvl_btn;
      btn_hold = lvl_btn ? btn_span + $urandom_range(0, 4)
                         : btn_span + $urandom_range(0, lp_span + 3);
    end
    s.func = ($urandom_range(0, 29) == 0);
    s.a    = lvl_a;
    s.b    = lvl_b;
    s.btn  = lvl_btn;
    case ($urandom_range(0, 15))
      0: s.a = !s.a;
      1: s.b = !s.b;
      2: s.btn = !s.btn;
      default: ;
    endcase
  endtask

  task automatic flag_field(input string name, input longint want_v, input longint got_v);
    errors++;
    $display("%0t mismatch %s: expected %0d, got %0d", $time, name, want_v, got_v);
  endtask

  // report sink
  initial begin : sink
    report_t     seen;
    report_t     want;
    int unsigned pause;
    wait (rst_ni);
    forever begin
      pause = rx_idle ? $urandom_range(0, 11) : 0;
      if (holdoff_pending) begin
        holdoff_pending = 1'b0;
        pause = HoldoffCycles;
      end
      if (pause != 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      seen.delta  = m_axis_tdata[15:0];
      seen.clicks = m_axis_tdata[31:16];
      seen.longs  = m_axis_tdata[47:32];
      seen.held   = m_axis_tdata[48];
      if (owed_reports.size() == 0) begin
        errors++;
        $display("%0t unexpected report: expected none, got %h", $time, m_axis_tdata);
      end else begin
        want = owed_reports.pop_front();
        if (seen.delta !== want.delta)
          flag_field("detent_delta", $signed(want.delta), $signed(seen.delta));
        if (seen.clicks !== want.clicks) flag_field("click_count", want.clicks, seen.clicks);
        if (seen.longs !== want.longs) flag_field("long_press_count", want.longs, seen.longs);
        if (seen.held !== want.held) flag_field("button_held", want.held, seen.held);
      end
    end
  end

  // stops the run when neither stream moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    sample_t          s;
    report_t          want;
    logic [FiltW-1:0] ab_set;
    logic [FiltW-1:0] btn_set;
    logic [HeldW-1:0] lp_set;
    int unsigned      n_items;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[k]) begin
      if (DirRows[k].is_cfg) begin
        write_reg(DirRows[k].idx, DirRows[k].val);
      end else begin
        s    = {DirRows[k].func, DirRows[k].a, DirRows[k].b, DirRows[k].btn};
        want = {DirRows[k].w_delta, DirRows[k].w_clicks, DirRows[k].w_longs,
                DirRows[k].w_held};
        push_sample(s, DirRows[k].typed, want);
      end
    end
    lvl_a = 1'b1;
    lvl_b = 1'b1;
    lvl_btn = 1'b1;

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin
          ab_set = '0;
          btn_set = '0;
          lp_set = HeldW'(1);
        end
        1: begin
          ab_set = FiltCountMax;
          btn_set = FiltCountMax;
          lp_set = HeldMax;
        end
        2: begin
          ab_set = FiltW'(1);
          btn_set = FiltW'(3);
          lp_set = '0;  // zero threshold acts as one
        end
        default: begin
          ab_set = FiltW'($urandom_range(0, 6));
          btn_set = FiltW'($urandom_range(0, 8));
          lp_set = HeldW'($urandom_range(1, 24));
        end
      endcase
      write_reg(CfgAbFilter, CfgDataW'(ab_set));
      write_reg(CfgBtnFilter, CfgDataW'(btn_set));
      write_reg(CfgLongPress, CfgDataW'(lp_set));
      tx_idle = (p % 3) != 0;
      rx_idle = (p % 4) != 0;
      if (p == 4) holdoff_pending = 1'b1;
      n_items = (p == 1) ? 30 : 66;
      for (int unsigned i = 0; i < n_items; i++) begin
        if (p == 5 && i == 30) drain_reports();
        random_sample(s);
        push_sample(s, 1'b0, '0);
      end
    end

    drain_reports();
    repeat (8) @(posedge clk_i);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
